// ===== src/ialu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants of the integer ALU
// Opcodes, payload structs of both channels and the condition flag set.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 4;

  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_AND  = 4'd2;
  localparam logic [OP_W-1:0] OP_OR   = 4'd3;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd4;
  localparam logic [OP_W-1:0] OP_SLL  = 4'd5;
  localparam logic [OP_W-1:0] OP_SLA  = 4'd6;
  localparam logic [OP_W-1:0] OP_SRL  = 4'd7;
  localparam logic [OP_W-1:0] OP_SRA  = 4'd8;
  localparam logic [OP_W-1:0] OP_MOVH = 4'd9;
  localparam logic [OP_W-1:0] OP_MOVL = 4'd10;
  localparam logic [OP_W-1:0] OP_DEC  = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    logic                     set_flags;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     zero_flag;
    logic                     negative_flag;
    logic                     overflow_flag;
    logic                     carry_flag;
  } out_t;

  typedef struct packed {
    logic z;
    logic n;
    logic v;
    logic c;
  } flags_t;

endpackage

// ===== src/ialu_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_dec: three-digit ASCII decimal conversion
// Clamps the operand to 0..999 and splits it into digits with reciprocal
// multiplies; also reports whether the clamped value is below 100 and 10.
// ----------------------------------------------------------------------------
module ialu_dec (
  input  logic [ialu_pkg::DATA_W-1:0] operand,
  output logic [ialu_pkg::DATA_W-1:0] ascii,
  output logic                        below_100,
  output logic                        below_10
);

  localparam logic [9:0]  DecMax   = 10'd999;
  localparam logic [5:0]  Recip100 = 6'd41;   // v*41 >> 12 == v/100 for v < 1000
  localparam logic [7:0]  Recip10  = 8'd205;  // r*205 >> 11 == r/10 for r < 100
  localparam logic [6:0]  Hundred  = 7'd100;
  localparam logic [3:0]  Ten      = 4'd10;
  localparam logic [3:0]  AsciiHi  = 4'h3;

  logic [9:0]  val;
  logic [15:0] prod_h;
  logic [3:0]  hund;
  logic [9:0]  rem_full;
  logic [6:0]  rem;
  logic [14:0] prod_t;
  logic [3:0]  tens;
  logic [6:0]  ones_full;
  logic [3:0]  ones;

  always_comb begin
    if (operand[ialu_pkg::DATA_W-1]) begin
      val = '0;
    end else if (operand[ialu_pkg::DATA_W-2:0] > {21'd0, DecMax}) begin
      val = DecMax;
    end else begin
      val = operand[9:0];
    end
  end

  assign prod_h    = {6'd0, val} * {10'd0, Recip100};
  assign hund      = prod_h[15:12];
  assign rem_full  = val - ({6'd0, hund} * {3'd0, Hundred});
  assign rem       = rem_full[6:0];
  assign prod_t    = {8'd0, rem} * {7'd0, Recip10};
  assign tens      = prod_t[14:11];
  assign ones_full = rem - ({3'd0, tens} * {3'd0, Ten});
  assign ones      = ones_full[3:0];

  assign ascii     = {8'h00, AsciiHi, hund, AsciiHi, tens, AsciiHi, ones};
  assign below_100 = (val < {3'd0, Hundred});
  assign below_10  = (val < {6'd0, Ten});

endmodule

// ===== src/ialu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_exec: operation datapath and flag update
// Computes the result of one item and the flag set that follows it.
// ----------------------------------------------------------------------------
module ialu_exec (
  input  ialu_pkg::in_t               item,
  input  ialu_pkg::flags_t            flags,
  output logic [ialu_pkg::DATA_W-1:0] result,
  output ialu_pkg::flags_t            flags_nxt
);

  localparam int W = ialu_pkg::DATA_W;

  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [4:0]   amt;
  logic [W:0]   sum;
  logic [W:0]   diff;
  logic [W:0]   shl;
  logic [W:0]   shr_l;
  logic [W:0]   shr_a;
  logic [W-1:0] dec_ascii;
  logic         dec_lt100;
  logic         dec_lt10;
  logic [W-1:0] res;
  logic         zn_upd;
  logic         vc_upd;
  logic         v_val;
  logic         c_val;

  assign a   = item.operand_a;
  assign b   = item.operand_b;
  assign amt = b[4:0];

  assign sum   = {1'b0, a} + {1'b0, b};
  // Carry out of a + ~b + 1 is the no-borrow bit.
  assign diff  = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
  // The extra bit catches the last bit shifted out; a zero amount leaves it 0.
  assign shl   = {1'b0, a} << amt;
  assign shr_l = {a, 1'b0} >> amt;
  assign shr_a = $unsigned($signed({a, 1'b0}) >>> amt);

  ialu_dec u_dec (
    .operand   (a),
    .ascii     (dec_ascii),
    .below_100 (dec_lt100),
    .below_10  (dec_lt10)
  );

  always_comb begin
    res    = '0;
    zn_upd = 1'b0;
    vc_upd = 1'b0;
    v_val  = 1'b0;
    c_val  = 1'b0;
    case (item.opcode)
      ialu_pkg::OP_ADD: begin
        res    = sum[W-1:0];
        zn_upd = 1'b1;
        vc_upd = 1'b1;
        v_val  = ~(a[W-1] ^ b[W-1]) & (a[W-1] ^ sum[W-1]);
        c_val  = sum[W];
      end
      ialu_pkg::OP_SUB: begin
        res    = diff[W-1:0];
        zn_upd = 1'b1;
        vc_upd = 1'b1;
        v_val  = (a[W-1] ^ b[W-1]) & (a[W-1] ^ diff[W-1]);
        c_val  = diff[W];
      end
      ialu_pkg::OP_AND: begin
        res    = a & b;
        zn_upd = 1'b1;
        vc_upd = 1'b1;
      end
      ialu_pkg::OP_OR: begin
        res    = a | b;
        zn_upd = 1'b1;
        vc_upd = 1'b1;
      end
      ialu_pkg::OP_XOR: begin
        res    = a ^ b;
        zn_upd = 1'b1;
        vc_upd = 1'b1;
      end
      ialu_pkg::OP_SLL, ialu_pkg::OP_SLA: begin
        res    = shl[W-1:0];
        zn_upd = 1'b1;
        vc_upd = 1'b1;
        c_val  = shl[W];
      end
      ialu_pkg::OP_SRL: begin
        res    = shr_l[W:1];
        zn_upd = 1'b1;
        vc_upd = 1'b1;
        c_val  = shr_l[0];
      end
      ialu_pkg::OP_SRA: begin
        res    = shr_a[W:1];
        zn_upd = 1'b1;
        vc_upd = 1'b1;
        c_val  = shr_a[0];
      end
      ialu_pkg::OP_MOVH: begin
        res = {b[15:0], a[15:0]};
      end
      ialu_pkg::OP_MOVL: begin
        res = {a[W-1:16], b[15:0]};
      end
      ialu_pkg::OP_DEC: begin
        res    = dec_ascii;
        vc_upd = 1'b1;
        v_val  = dec_lt100;
        c_val  = dec_lt10;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    flags_nxt = flags;
    if (item.set_flags) begin
      if (zn_upd) begin
        flags_nxt.z = (res == '0);
        flags_nxt.n = res[W-1];
      end
      if (vc_upd) begin
        flags_nxt.v = v_val;
        flags_nxt.c = c_val;
      end
    end
  end

  assign result = res;

endmodule

// ===== src/integer_alu_with_condition_flags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_with_condition_flags: 32-bit integer ALU with held NZVC flags
// Two-register pipeline around a single-pass execute datapath.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle on each channel unless the
// output is stalled, and returns exactly one result transfer for every input
// transfer, in order. An item is captured in an input register, goes through
// the execute logic, and lands in the output register, so a result is offered
// only after both registers have taken it; throughput is one item per cycle
// while out_ready is not held low, set by the single execute stage between
// those two registers. The held flags are
// updated at the moment an item moves into the output register, so every
// result carries the flags as they stand after that item. Both registers
// advance whenever the output register is empty or is being drained, which
// lets a new item come in while a finished result is still waiting.
module integer_alu_with_condition_flags (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ialu_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ialu_pkg::out_t   out_data
);

  // Input stage.
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  ialu_pkg::in_t    s1_item_r;

  // Output stage and held flags.
  logic             out_valid_r;
  logic             out_valid_nxt;
  ialu_pkg::out_t   out_data_r;
  ialu_pkg::flags_t flags_r;

  logic                        s1_adv;
  logic [ialu_pkg::DATA_W-1:0] exec_result;
  ialu_pkg::flags_t            flags_nxt;

  // The item in the input register moves on when the output register is
  // free or is handing its result over in this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = in_valid ? 1'b1 : (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && !out_ready);

  ialu_exec u_exec (
    .item      (s1_item_r),
    .flags     (flags_r),
    .result    (exec_result),
    .flags_nxt (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= s1_valid_nxt;
      end
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r.result        <= exec_result;
      out_data_r.zero_flag     <= flags_nxt.z;
      out_data_r.negative_flag <= flags_nxt.n;
      out_data_r.overflow_flag <= flags_nxt.v;
      out_data_r.carry_flag    <= flags_nxt.c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A waiting result always reports the flags that are held right now.
  a_out_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.zero_flag == flags_r.z) &&
                    (out_data_r.negative_flag == flags_r.n) &&
                    (out_data_r.overflow_flag == flags_r.v) &&
                    (out_data_r.carry_flag == flags_r.c))
    else $error("output flags differ from held flags");

  // An item without set_flags never changes the held flags.
  a_no_set_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_item_r.set_flags) |=> $stable(flags_r))
    else $error("flags changed without set_flags");

  // Move operations leave every flag alone.
  a_move_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_item_r.opcode == ialu_pkg::OP_MOVH ||
                s1_item_r.opcode == ialu_pkg::OP_MOVL)) |=> $stable(flags_r))
    else $error("move operation changed the flags");

  // A stalled item stays in the input register until it moves on.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("input register dropped an item");

endmodule
